@@ rtl/core/scrg_pkg.sv @@
// ----------------------------------------------------------------------------
// Seeded crown region grower package
// Shared field widths, register indexes, beat types and sequencer states.
// ----------------------------------------------------------------------------
package scrg_pkg;

  localparam int HGT_W   = 16;
  localparam int LBL_W   = 10;
  localparam int RATIO_W = 16;
  localparam int DIST_W  = 9;
  localparam int SIZE_W  = 9;
  localparam int PADDR_W = 5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SEED_RATIO  = 3'd0;
  localparam logic [2:0] REG_CROWN_RATIO = 3'd1;
  localparam logic [2:0] REG_TREE_FLOOR  = 3'd2;
  localparam logic [2:0] REG_MAX_DIST    = 3'd3;
  localparam logic [2:0] REG_ROWS_USED   = 3'd4;
  localparam logic [2:0] REG_COLS_USED   = 3'd5;

  // Register reset values.
  localparam logic [RATIO_W-1:0] SEED_RATIO_RST  = 16'd29491;
  localparam logic [RATIO_W-1:0] CROWN_RATIO_RST = 16'd36045;
  localparam logic [HGT_W-1:0]   TREE_FLOOR_RST  = 16'd512;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST    = 9'd10;
  localparam logic [SIZE_W-1:0]  ROWS_USED_RST   = 9'd256;
  localparam logic [SIZE_W-1:0]  COLS_USED_RST   = 9'd256;

  // Item actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Neighbor order within one pixel: up, left, right, down.
  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_DOWN  = 2'd3;

  typedef struct packed {
    logic             action;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [HGT_W-1:0] height;
    logic [LBL_W-1:0] seed_label;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_row;
    logic [7:0]       out_col;
    logic [LBL_W-1:0] crown_label;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SW_RD,
    ST_SW_ST,
    ST_SW_WR,
    ST_P_RD,
    ST_P_CHK,
    ST_P_NRD,
    ST_P_MUL,
    ST_P_CMP
  } grow_state_t;

endpackage

@@ rtl/core/seeded_crown_region_grower.sv @@
// ----------------------------------------------------------------------------
// Seeded crown region grower
// Loads a height raster with seed labels, grows crowns by passes and
// returns final crown labels on read beats.
// ----------------------------------------------------------------------------
// Load and read beats are taken one per cycle while busy is low. A read beat
// returns its label on the out_ ports with out_strobe in the next cycle;
// the receiver cannot stall it. The load marked last raises busy for the whole
// grow: a clearing sweep of the crown tables, a tally sweep that reads, looks
// up and writes back each used pixel, then passes that read and check each
// interior pixel and read, multiply and compare each neighbor of a pixel that
// still tests its neighbors; each pass is followed by another clearing and
// tally sweep. The number of passes depends on the data.
module seeded_crown_region_grower #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_LABELS = 1023
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  scrg_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output scrg_pkg::out_item_t            out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scrg_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW     = RW + CW;
  localparam int DEPTH  = 2 ** AW;
  localparam int LAW    = (MAX_LABELS > 0) ? $clog2(MAX_LABELS + 1) : 1;
  localparam int LDEPTH = MAX_LABELS + 1;
  localparam int CNTW   = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int SUMW   = scrg_pkg::HGT_W + CNTW;
  localparam int PHW    = scrg_pkg::HGT_W + CNTW;
  localparam int MW     = SUMW + scrg_pkg::RATIO_W;
  localparam int HW     = scrg_pkg::HGT_W;
  localparam int LW     = scrg_pkg::LBL_W;

  // Configuration registers.
  logic [scrg_pkg::RATIO_W-1:0] seed_ratio_r, crown_ratio_r;
  logic [HW-1:0]                tree_floor_r;
  logic [scrg_pkg::DIST_W-1:0]  max_dist_r;
  logic [scrg_pkg::SIZE_W-1:0]  rows_used_r, cols_used_r;
  logic                         cfg_we;
  logic [2:0]                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_ratio_r  <= scrg_pkg::SEED_RATIO_RST;
      crown_ratio_r <= scrg_pkg::CROWN_RATIO_RST;
      tree_floor_r  <= scrg_pkg::TREE_FLOOR_RST;
      max_dist_r    <= scrg_pkg::MAX_DIST_RST;
      rows_used_r   <= scrg_pkg::ROWS_USED_RST;
      cols_used_r   <= scrg_pkg::COLS_USED_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        scrg_pkg::REG_SEED_RATIO:  seed_ratio_r  <= pwdata[15:0];
        scrg_pkg::REG_CROWN_RATIO: crown_ratio_r <= pwdata[15:0];
        scrg_pkg::REG_TREE_FLOOR:  tree_floor_r  <= pwdata[15:0];
        scrg_pkg::REG_MAX_DIST:    max_dist_r    <= pwdata[8:0];
        scrg_pkg::REG_ROWS_USED:   rows_used_r   <= pwdata[8:0];
        scrg_pkg::REG_COLS_USED:   cols_used_r   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      scrg_pkg::REG_SEED_RATIO:  prdata = 32'(seed_ratio_r);
      scrg_pkg::REG_CROWN_RATIO: prdata = 32'(crown_ratio_r);
      scrg_pkg::REG_TREE_FLOOR:  prdata = 32'(tree_floor_r);
      scrg_pkg::REG_MAX_DIST:    prdata = 32'(max_dist_r);
      scrg_pkg::REG_ROWS_USED:   prdata = 32'(rows_used_r);
      scrg_pkg::REG_COLS_USED:   prdata = 32'(cols_used_r);
      default:                   prdata = 32'd0;
    endcase
  end

  // Used raster size, saturated to the array and with zero taken as one.
  logic [15:0] rows_n, cols_n;
  logic        has_interior;

  always_comb begin
    if (16'(rows_used_r) > 16'(MAX_ROWS))   rows_n = 16'(MAX_ROWS);
    else if (rows_used_r == '0)             rows_n = 16'd1;
    else                                    rows_n = 16'(rows_used_r);
    if (16'(cols_used_r) > 16'(MAX_COLS))   cols_n = 16'(MAX_COLS);
    else if (cols_used_r == '0)             cols_n = 16'd1;
    else                                    cols_n = 16'(cols_used_r);
  end

  assign has_interior = (rows_n >= 16'd3) && (cols_n >= 16'd3);

  // Input beat decode.
  logic acc, load_acc, read_acc;
  scrg_pkg::grow_state_t state_r, state_nxt;

  assign busy     = (state_r != scrg_pkg::ST_IDLE);
  assign acc      = start && !busy;
  assign load_acc = acc && (in_item.action == scrg_pkg::ACT_LOAD);
  assign read_acc = acc && (in_item.action == scrg_pkg::ACT_READ);

  // Load position in raster order.
  logic [RW-1:0] ld_row_r, ld_row_nxt, ld_row_eff;
  logic [CW-1:0] ld_col_r, ld_col_nxt, ld_col_eff;
  logic [LW-1:0] ld_lab;
  logic [AW-1:0] ld_addr;
  logic          ld_wrap;

  assign ld_wrap    = (16'(ld_row_r) >= rows_n) || (16'(ld_col_r) >= cols_n);
  assign ld_row_eff = ld_wrap ? '0 : ld_row_r;
  assign ld_col_eff = ld_wrap ? '0 : ld_col_r;
  assign ld_lab     = (32'(in_item.seed_label) > 32'(MAX_LABELS)) ? '0 : in_item.seed_label;
  assign ld_addr    = {ld_row_eff, ld_col_eff};

  always_comb begin
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    if (load_acc) begin
      if (in_item.last) begin
        ld_row_nxt = '0;
        ld_col_nxt = '0;
      end else if (16'(ld_col_eff) + 16'd1 >= cols_n) begin
        ld_col_nxt = '0;
        ld_row_nxt = (16'(ld_row_eff) + 16'd1 >= rows_n) ? '0 : ld_row_eff + 1'b1;
      end else begin
        ld_row_nxt = ld_row_eff;
        ld_col_nxt = ld_col_eff + 1'b1;
      end
    end
  end

  // Memory read data.
  logic [HW-1:0]   hgt_q, shgt_q;
  logic [LW-1:0]   lbl_q, nxl_q;
  logic            tst_q;
  logic [RW-1:0]   srow_q;
  logic [CW-1:0]   scol_q;
  logic [SUMW-1:0] sum_q;
  logic [CNTW-1:0] cnt_q;

  // Sequencer counters and flags.
  logic [RW-1:0]  r_r, r_nxt;
  logic [CW-1:0]  c_r, c_nxt;
  logic [1:0]     k_r, k_nxt;
  logic [LAW-1:0] lclr_r, lclr_nxt;
  logic [LW-1:0]  lab_r, lab_nxt;
  logic           first_r, first_nxt;
  logic           changed_r, changed_nxt;

  // Pixel and neighbor addresses.
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [AW-1:0] cur_addr, nb_addr;

  always_comb begin
    case (k_r)
      scrg_pkg::NB_UP: begin
        nr = r_r - 1'b1;
        nc = c_r;
      end
      scrg_pkg::NB_LEFT: begin
        nr = r_r;
        nc = c_r - 1'b1;
      end
      scrg_pkg::NB_RIGHT: begin
        nr = r_r;
        nc = c_r + 1'b1;
      end
      default: begin
        nr = r_r + 1'b1;
        nc = c_r;
      end
    endcase
  end

  assign cur_addr = {r_r, c_r};
  assign nb_addr  = {nr, nc};

  // Scan position tests.
  logic p_last_col, p_last_row, pass_end, s_end, clr_done, act;

  assign p_last_col = (16'(c_r) == cols_n - 16'd2);
  assign p_last_row = (16'(r_r) == rows_n - 16'd2);
  assign pass_end   = p_last_col && p_last_row;
  assign s_end      = (16'(c_r) == cols_n - 16'd1) && (16'(r_r) == rows_n - 16'd1);
  assign clr_done   = (lclr_r == LAW'(MAX_LABELS));
  assign act        = (first_r || !tst_q) && (lbl_q != '0);

  // Join test: products are registered, compares follow in the next cycle.
  logic [31:0]     prod_seed_r;
  logic [PHW-1:0]  prod_hc_r;
  logic [MW-1:0]   prod_sr_r;
  logic [HW-1:0]   h_r;
  logic            nlab_zero_r, cnt_zero_r;

  always_ff @(posedge clk) begin
    if (state_r == scrg_pkg::ST_P_MUL) begin
      prod_seed_r <= 32'(shgt_q) * 32'(seed_ratio_r);
      prod_hc_r   <= PHW'(hgt_q) * PHW'(cnt_q);
      prod_sr_r   <= MW'(sum_q) * MW'(crown_ratio_r);
      h_r         <= hgt_q;
      nlab_zero_r <= (lbl_q == '0);
      cnt_zero_r  <= (cnt_q == '0);
    end
  end

  logic          c_mean, claim_ok;
  logic [RW-1:0] dr;
  logic [CW-1:0] dc;

  always_comb begin
    dr     = (srow_q >= nr) ? srow_q - nr : nr - srow_q;
    dc     = (scol_q >= nc) ? scol_q - nc : nc - scol_q;
    c_mean = cnt_zero_r ? (h_r != '0) : ({prod_hc_r, 16'h0} > prod_sr_r);
    claim_ok = (h_r > tree_floor_r)
            && ({h_r, 16'h0} > prod_seed_r)
            && c_mean
            && ((21'(h_r) * 21'd20) <= (21'(shgt_q) * 21'd21))
            && (16'(dr) < 16'(max_dist_r))
            && (16'(dc) < 16'(max_dist_r))
            && nlab_zero_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scrg_pkg::ST_IDLE:  if (load_acc && in_item.last) state_nxt = scrg_pkg::ST_CLR;
      scrg_pkg::ST_CLR:   if (clr_done) state_nxt = scrg_pkg::ST_SW_RD;
      scrg_pkg::ST_SW_RD: state_nxt = scrg_pkg::ST_SW_ST;
      scrg_pkg::ST_SW_ST: state_nxt = scrg_pkg::ST_SW_WR;
      scrg_pkg::ST_SW_WR: begin
        if (!s_end)                                      state_nxt = scrg_pkg::ST_SW_RD;
        else if (has_interior && (first_r || changed_r)) state_nxt = scrg_pkg::ST_P_RD;
        else                                             state_nxt = scrg_pkg::ST_IDLE;
      end
      scrg_pkg::ST_P_RD:  state_nxt = scrg_pkg::ST_P_CHK;
      scrg_pkg::ST_P_CHK: begin
        if (act)           state_nxt = scrg_pkg::ST_P_NRD;
        else if (pass_end) state_nxt = scrg_pkg::ST_CLR;
        else               state_nxt = scrg_pkg::ST_P_RD;
      end
      scrg_pkg::ST_P_NRD: state_nxt = scrg_pkg::ST_P_MUL;
      scrg_pkg::ST_P_MUL: state_nxt = scrg_pkg::ST_P_CMP;
      scrg_pkg::ST_P_CMP: begin
        if (k_r != scrg_pkg::NB_DOWN) state_nxt = scrg_pkg::ST_P_NRD;
        else if (pass_end)            state_nxt = scrg_pkg::ST_CLR;
        else                          state_nxt = scrg_pkg::ST_P_RD;
      end
      default: state_nxt = scrg_pkg::ST_IDLE;
    endcase
  end

  // Counter and flag updates.
  logic pix_done;

  always_comb begin
    r_nxt       = r_r;
    c_nxt       = c_r;
    k_nxt       = k_r;
    lclr_nxt    = lclr_r;
    lab_nxt     = lab_r;
    first_nxt   = first_r;
    changed_nxt = changed_r;
    pix_done    = 1'b0;
    case (state_r)
      scrg_pkg::ST_IDLE: begin
        if (load_acc && in_item.last) begin
          lclr_nxt  = '0;
          first_nxt = 1'b1;
        end
      end
      scrg_pkg::ST_CLR: begin
        if (clr_done) begin
          r_nxt = '0;
          c_nxt = '0;
        end else begin
          lclr_nxt = lclr_r + 1'b1;
        end
      end
      scrg_pkg::ST_SW_WR: begin
        if (s_end) begin
          r_nxt       = RW'(1);
          c_nxt       = CW'(1);
          changed_nxt = 1'b0;
        end else if (16'(c_r) == cols_n - 16'd1) begin
          c_nxt = '0;
          r_nxt = r_r + 1'b1;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      scrg_pkg::ST_P_CHK: begin
        if (act) begin
          k_nxt   = scrg_pkg::NB_UP;
          lab_nxt = lbl_q;
        end else begin
          pix_done = 1'b1;
        end
      end
      scrg_pkg::ST_P_CMP: begin
        if (claim_ok) changed_nxt = 1'b1;
        if (k_r != scrg_pkg::NB_DOWN) k_nxt = k_r + 1'b1;
        else                          pix_done = 1'b1;
      end
      default: ;
    endcase
    // Step to the next interior pixel of the pass.
    if (pix_done) begin
      if (pass_end) begin
        first_nxt = 1'b0;
        lclr_nxt  = '0;
      end else if (p_last_col) begin
        c_nxt = CW'(1);
        r_nxt = r_r + 1'b1;
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= scrg_pkg::ST_IDLE;
      ld_row_r  <= '0;
      ld_col_r  <= '0;
      first_r   <= 1'b0;
      changed_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ld_row_r  <= ld_row_nxt;
      ld_col_r  <= ld_col_nxt;
      first_r   <= first_nxt;
      changed_r <= changed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r    <= r_nxt;
    c_r    <= c_nxt;
    k_r    <= k_nxt;
    lclr_r <= lclr_nxt;
    lab_r  <= lab_nxt;
  end

  // Memory port control.
  logic            hgt_we, hgt_re, lbl_we, lbl_re, nxl_we, nxl_re, tst_we, tst_re;
  logic            seed_we, seed_re, st_we, st_re;
  logic [AW-1:0]   hgt_wa, hgt_ra, lbl_wa, lbl_ra, nxl_wa, tst_wa, tst_ra;
  logic [HW-1:0]   hgt_wd;
  logic [LW-1:0]   lbl_wd, nxl_wd;
  logic            tst_wd;
  logic [LAW-1:0]  seed_wa, seed_ra, st_wa, st_ra;
  logic [SUMW-1:0] sum_wd;
  logic [CNTW-1:0] cnt_wd;

  always_comb begin
    hgt_we  = 1'b0;
    hgt_re  = 1'b0;
    hgt_wa  = ld_addr;
    hgt_ra  = cur_addr;
    hgt_wd  = in_item.height;
    lbl_we  = 1'b0;
    lbl_re  = 1'b0;
    lbl_wa  = ld_addr;
    lbl_ra  = cur_addr;
    lbl_wd  = ld_lab;
    nxl_we  = 1'b0;
    nxl_re  = 1'b0;
    nxl_wa  = ld_addr;
    nxl_wd  = ld_lab;
    tst_we  = 1'b0;
    tst_re  = 1'b0;
    tst_wa  = cur_addr;
    tst_ra  = cur_addr;
    tst_wd  = (lbl_q != '0);
    seed_we = 1'b0;
    seed_re = 1'b0;
    seed_wa = LAW'(ld_lab);
    seed_ra = LAW'(lbl_q);
    st_we   = 1'b0;
    st_re   = 1'b0;
    st_wa   = lclr_r;
    st_ra   = LAW'(nxl_q);
    sum_wd  = '0;
    cnt_wd  = '0;
    case (state_r)
      scrg_pkg::ST_IDLE: begin
        if (load_acc) begin
          hgt_we  = 1'b1;
          lbl_we  = 1'b1;
          nxl_we  = 1'b1;
          seed_we = (ld_lab != '0);
        end
        if (read_acc) begin
          lbl_re = 1'b1;
          lbl_ra = {RW'(in_item.row), CW'(in_item.col)};
        end
      end
      scrg_pkg::ST_CLR: st_we = 1'b1;
      scrg_pkg::ST_SW_RD: begin
        hgt_re = 1'b1;
        lbl_re = 1'b1;
        nxl_re = 1'b1;
      end
      scrg_pkg::ST_SW_ST: st_re = 1'b1;
      scrg_pkg::ST_SW_WR: begin
        lbl_we = 1'b1;
        lbl_wa = cur_addr;
        lbl_wd = nxl_q;
        tst_we = 1'b1;
        st_we  = (nxl_q != '0);
        st_wa  = LAW'(nxl_q);
        sum_wd = sum_q + SUMW'(hgt_q);
        cnt_wd = cnt_q + 1'b1;
      end
      scrg_pkg::ST_P_RD: begin
        lbl_re = 1'b1;
        tst_re = 1'b1;
      end
      scrg_pkg::ST_P_CHK: begin
        seed_re = act;
        st_re   = act;
        st_ra   = LAW'(lbl_q);
      end
      scrg_pkg::ST_P_NRD: begin
        hgt_re = 1'b1;
        hgt_ra = nb_addr;
        lbl_re = 1'b1;
        lbl_ra = nb_addr;
      end
      scrg_pkg::ST_P_CMP: begin
        nxl_we = claim_ok;
        nxl_wa = nb_addr;
        nxl_wd = lab_r;
      end
      default: ;
    endcase
  end

  // Raster memories.
  logic [HW-1:0] hgt_mem [DEPTH];
  logic [LW-1:0] lbl_mem [DEPTH];
  logic [LW-1:0] nxl_mem [DEPTH];
  logic          tst_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (hgt_we) hgt_mem[hgt_wa] <= hgt_wd;
    if (hgt_re) hgt_q <= hgt_mem[hgt_ra];
  end

  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    if (lbl_re) lbl_q <= lbl_mem[lbl_ra];
  end

  always_ff @(posedge clk) begin
    if (nxl_we) nxl_mem[nxl_wa] <= nxl_wd;
    if (nxl_re) nxl_q <= nxl_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (tst_we) tst_mem[tst_wa] <= tst_wd;
    if (tst_re) tst_q <= tst_mem[tst_ra];
  end

  // Per-label memories: seed position and height, crown sum and count.
  logic [RW-1:0]   srow_mem [LDEPTH];
  logic [CW-1:0]   scol_mem [LDEPTH];
  logic [HW-1:0]   shgt_mem [LDEPTH];
  logic [SUMW-1:0] sum_mem  [LDEPTH];
  logic [CNTW-1:0] cnt_mem  [LDEPTH];

  always_ff @(posedge clk) begin
    if (seed_we) begin
      srow_mem[seed_wa] <= ld_row_eff;
      scol_mem[seed_wa] <= ld_col_eff;
      shgt_mem[seed_wa] <= in_item.height;
    end
    if (seed_re) begin
      srow_q <= srow_mem[seed_ra];
      scol_q <= scol_mem[seed_ra];
      shgt_q <= shgt_mem[seed_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      sum_mem[st_wa] <= sum_wd;
      cnt_mem[st_wa] <= cnt_wd;
    end
    if (st_re) begin
      sum_q <= sum_mem[st_ra];
      cnt_q <= cnt_mem[st_ra];
    end
  end

  // Result beat, in the cycle after the read beat.
  logic       out_strobe_r, in_rng_r;
  logic [7:0] orow_r, ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= read_acc;
  end

  always_ff @(posedge clk) begin
    if (read_acc) begin
      orow_r   <= in_item.row;
      ocol_r   <= in_item.col;
      in_rng_r <= (16'(in_item.row) < rows_n) && (16'(in_item.col) < cols_n);
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_item.out_row     = orow_r;
  assign out_item.out_col     = ocol_r;
  assign out_item.crown_label = in_rng_r ? lbl_q : '0;

endmodule

@@ rtl/core/scrg_checker.sv @@
// ----------------------------------------------------------------------------
// Seeded crown region grower port checker
// Watches the item and result beats on the top level's ports.
// ----------------------------------------------------------------------------
module scrg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input scrg_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input scrg_pkg::out_item_t out_item
);

  // An accepted read beat gives a result beat in the next cycle.
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.action == scrg_pkg::ACT_READ)) |=> out_strobe)
    else $error("read beat without result beat");

  // Every result beat follows an accepted read beat.
  a_result_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && (in_item.action == scrg_pkg::ACT_READ)))
    else $error("result beat without read beat");

  // A result beat echoes the address of its read beat.
  a_result_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_item.out_row == $past(in_item.row))
                 && (out_item.out_col == $past(in_item.col))))
    else $error("result address does not match read beat");

  // The last load starts the grow.
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.action == scrg_pkg::ACT_LOAD) && in_item.last) |=> busy)
    else $error("last load did not start the grow");

endmodule

bind seeded_crown_region_grower scrg_checker u_scrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

@@ tb/sv/seeded_crown_region_grower_tb.sv @@
// ----------------------------------------------------------------------------
// Seeded crown region grower testbench
// Loads small height rasters with seed labels, lets the block grow crowns and
// reads the labels back. A behavioral copy of the grower predicts every read
// beat, and each strobed result is checked field by field against it.
// ----------------------------------------------------------------------------
module seeded_crown_region_grower_tb;

  localparam int ROWS_MAX    = 256;
  localparam int COLS_MAX    = 256;
  localparam int LABEL_TOP   = 1023;
  localparam int CELLS       = ROWS_MAX * COLS_MAX;
  localparam int CYCLE_LIMIT = 8000000;

  typedef enum {PH_LOADING, PH_GROWING, PH_DONE} grow_phase_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  scrg_pkg::in_item_t           in_item;
  logic                         out_strobe;
  scrg_pkg::out_item_t          out_item;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [scrg_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  seeded_crown_region_grower DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Clock with a period of 4.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Grower state as the testbench expects it.
  logic [scrg_pkg::HGT_W-1:0] hgt_mem  [CELLS];
  logic [scrg_pkg::LBL_W-1:0] lbl_mem  [CELLS];
  logic [scrg_pkg::LBL_W-1:0] nxt_mem  [CELLS];
  bit                         tested   [CELLS];
  bit                         written  [CELLS];
  logic [7:0]                 seed_row [LABEL_TOP+1];
  logic [7:0]                 seed_col [LABEL_TOP+1];
  logic [scrg_pkg::HGT_W-1:0] seed_hgt [LABEL_TOP+1];
  longint unsigned            crown_sum   [LABEL_TOP+1];
  longint unsigned            crown_count [LABEL_TOP+1];
  grow_phase_t                phase;
  bit                         claimed;
  int unsigned                load_r, load_c;
  int unsigned                seed_ratio, crown_ratio, tree_floor, max_dist;
  int unsigned                rows_used, cols_used;

  scrg_pkg::out_item_t        expected_labels[$];
  int                         fails;
  int                         idle_pct;
  int                         items_sent;
  int                         cycles;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
    if (v > top) return top;
    if (v == 0) return 1;
    return v;
  endfunction

  function automatic int unsigned eff_rows();
    return clamp_size(rows_used, ROWS_MAX);
  endfunction

  function automatic int unsigned eff_cols();
    return clamp_size(cols_used, COLS_MAX);
  endfunction

  // Recount crown sums and sizes over the used area.
  task automatic tally_crowns();
    int unsigned i;
    for (int l = 0; l <= LABEL_TOP; l++) begin
      crown_sum[l] = 0;
      crown_count[l] = 0;
    end
    for (int unsigned r = 0; r < eff_rows(); r++) begin
      for (int unsigned c = 0; c < eff_cols(); c++) begin
        i = r * COLS_MAX + c;
        if (lbl_mem[i] != 0) begin
          crown_sum[lbl_mem[i]] += hgt_mem[i];
          crown_count[lbl_mem[i]] += 1;
        end
      end
    end
  endtask

  // One neighbor test: all join conditions against the previous pass.
  task automatic try_join(int unsigned lab, int unsigned nr, int unsigned nc);
    int unsigned     ni;
    longint unsigned h, sh, cnt;
    bit              mean_ok;
    int unsigned     dr, dc;
    ni = nr * COLS_MAX + nc;
    h = hgt_mem[ni];
    sh = seed_hgt[lab];
    cnt = crown_count[lab];
    dr = (seed_row[lab] > nr) ? seed_row[lab] - nr : nr - seed_row[lab];
    dc = (seed_col[lab] > nc) ? seed_col[lab] - nc : nc - seed_col[lab];
    if (cnt != 0) mean_ok = h * cnt * 65536 > crown_sum[lab] * crown_ratio;
    else mean_ok = h > 0;
    if (h <= tree_floor) return;
    if (h * 65536 <= sh * seed_ratio) return;
    if (!mean_ok) return;
    if (h * 20 > sh * 21) return;
    if (dr >= max_dist || dc >= max_dist) return;
    if (lbl_mem[ni] != 0) return;
    nxt_mem[ni] = 10'(lab);
    claimed = 1'b1;
  endtask

  // Grow passes until a pass claims nothing.
  task automatic grow_crowns();
    int unsigned i, lab;
    phase = PH_GROWING;
    tally_crowns();
    for (int k = 0; k < CELLS; k++) nxt_mem[k] = lbl_mem[k];
    do begin
      claimed = 1'b0;
      for (int unsigned r = 1; r + 1 < eff_rows(); r++) begin
        for (int unsigned c = 1; c + 1 < eff_cols(); c++) begin
          i = r * COLS_MAX + c;
          lab = lbl_mem[i];
          if (!tested[i] && lab != 0) begin
            try_join(lab, r - 1, c);
            try_join(lab, r, c - 1);
            try_join(lab, r, c + 1);
            try_join(lab, r + 1, c);
          end
        end
      end
      for (int unsigned r = 0; r < eff_rows(); r++) begin
        for (int unsigned c = 0; c < eff_cols(); c++) begin
          i = r * COLS_MAX + c;
          tested[i] = (lbl_mem[i] != 0);
          lbl_mem[i] = nxt_mem[i];
        end
      end
      tally_crowns();
    end while (claimed);
    phase = PH_DONE;
  endtask

  // Update the expected state for one accepted beat.
  task automatic predict_item(scrg_pkg::in_item_t it);
    scrg_pkg::out_item_t res;
    int unsigned         i;
    if (it.action == scrg_pkg::ACT_READ) begin
      res.out_row = it.row;
      res.out_col = it.col;
      res.crown_label = '0;
      if (it.row < eff_rows() && it.col < eff_cols())
        res.crown_label = lbl_mem[it.row * COLS_MAX + it.col];
      expected_labels = {expected_labels, res};
      return;
    end
    if (phase == PH_DONE) begin
      for (int k = 0; k < CELLS; k++) tested[k] = 1'b0;
      phase = PH_LOADING;
    end
    if (load_r >= eff_rows() || load_c >= eff_cols()) begin
      load_r = 0;
      load_c = 0;
    end
    i = load_r * COLS_MAX + load_c;
    hgt_mem[i] = it.height;
    lbl_mem[i] = it.seed_label;
    nxt_mem[i] = it.seed_label;
    tested[i] = 1'b0;
    written[i] = 1'b1;
    if (it.seed_label != 0) begin
      seed_row[it.seed_label] = 8'(load_r);
      seed_col[it.seed_label] = 8'(load_c);
      seed_hgt[it.seed_label] = it.height;
    end
    load_c++;
    if (load_c >= eff_cols()) begin
      load_c = 0;
      load_r++;
      if (load_r >= eff_rows()) load_r = 0;
    end
    if (it.last) begin
      load_r = 0;
      load_c = 0;
      grow_crowns();
    end
  endtask

  // Offer one beat, with random idle cycles first, and wait until taken.
  task automatic send_item(scrg_pkg::in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_item(it);
    items_sent++;
  endtask

  // Wait until the grow is over and every read has returned.
  task automatic settle();
    start <= 1'b0;
    repeat (4) @(posedge clk);
    while (busy || expected_labels.size() != 0) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic cfg_write(logic [2:0] idx, int unsigned val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      scrg_pkg::REG_SEED_RATIO:  seed_ratio  = val & 16'hFFFF;
      scrg_pkg::REG_CROWN_RATIO: crown_ratio = val & 16'hFFFF;
      scrg_pkg::REG_TREE_FLOOR:  tree_floor  = val & 16'hFFFF;
      scrg_pkg::REG_MAX_DIST:    max_dist    = val & 9'h1FF;
      scrg_pkg::REG_ROWS_USED:   rows_used   = val & 9'h1FF;
      scrg_pkg::REG_COLS_USED:   cols_used   = val & 9'h1FF;
      default: ;
    endcase
  endtask

  task automatic cfg_all(int unsigned sr, int unsigned cr, int unsigned tf,
                         int unsigned md, int unsigned nr, int unsigned nc);
    settle();
    cfg_write(scrg_pkg::REG_SEED_RATIO, sr);
    cfg_write(scrg_pkg::REG_CROWN_RATIO, cr);
    cfg_write(scrg_pkg::REG_TREE_FLOOR, tf);
    cfg_write(scrg_pkg::REG_MAX_DIST, md);
    cfg_write(scrg_pkg::REG_ROWS_USED, nr);
    cfg_write(scrg_pkg::REG_COLS_USED, nc);
  endtask

  function automatic scrg_pkg::in_item_t load_beat(int unsigned h, int unsigned lab, bit fin);
    scrg_pkg::in_item_t it;
    it.action = scrg_pkg::ACT_LOAD;
    it.row = 8'($urandom_range(0, 255));
    it.col = 8'($urandom_range(0, 255));
    it.height = 16'(h);
    it.seed_label = 10'(lab);
    it.last = fin;
    return it;
  endfunction

  // Read beat; an address inside the used area that was never loaded is
  // replaced by the first pixel.
  function automatic scrg_pkg::in_item_t read_beat(int unsigned r, int unsigned c);
    scrg_pkg::in_item_t it;
    it = load_beat($urandom_range(0, 65535), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
    it.action = scrg_pkg::ACT_READ;
    if (r < eff_rows() && c < eff_cols() && !written[r * COLS_MAX + c]) begin
      r = 0;
      c = 0;
    end
    it.row = 8'(r);
    it.col = 8'(c);
    return it;
  endfunction

  task automatic random_read();
    if ($urandom_range(0, 9) < 7)
      send_item(read_beat($urandom_range(0, eff_rows() - 1), $urandom_range(0, eff_cols() - 1)));
    else
      send_item(read_beat($urandom_range(0, 255), $urandom_range(0, 255)));
  endtask

  // Load a whole frame of random crowns, then read labels back.
  task automatic random_frame(int unsigned extra);
    int unsigned n, lab, h;
    int unsigned pool[3];
    foreach (pool[k]) pool[k] = ($urandom_range(0, 9) == 0) ? LABEL_TOP : $urandom_range(1, 1023);
    n = eff_rows() * eff_cols() + extra;
    for (int unsigned k = 0; k < n; k++) begin
      lab = ($urandom_range(0, 99) < 8) ? pool[$urandom_range(0, 2)] : 0;
      case ($urandom_range(0, 19))
        0:       h = 0;
        1, 2:    h = $urandom_range(0, 65535);
        default: h = lab != 0 ? $urandom_range(16'h1400, 16'h2000)
                              : $urandom_range(16'h0800, 16'h2100);
      endcase
      send_item(load_beat(h, lab, k == n - 1));
      if ($urandom_range(0, 99) < 6) random_read();
    end
    repeat ($urandom_range(4, 24)) random_read();
  endtask

  // Reset values; reads before any grow return the seed labels.
  task automatic test_reset_values();
    send_item(load_beat(16'hFFFF, LABEL_TOP, 1'b0));
    send_item(load_beat(16'h0000, 1, 1'b0));
    send_item(load_beat(16'h1234, 0, 1'b0));
    send_item(read_beat(0, 0));
    send_item(read_beat(0, 1));
    send_item(read_beat(0, 2));
  endtask

  // One crown in a 3 by 3 frame with a distance limit of 256.
  task automatic test_single_crown();
    cfg_all(0, 65535, 0, 256, 3, 3);
    for (int unsigned k = 0; k < 9; k++) begin
      case (k)
        4:       send_item(load_beat(16'h1000, LABEL_TOP, 1'b0));
        1, 3:    send_item(load_beat(16'h1050, 0, 1'b0));
        5:       send_item(load_beat(16'h10D0, 0, 1'b0));
        default: send_item(load_beat(16'h0F00, 0, k == 8));
      endcase
    end
    for (int unsigned k = 0; k < 9; k++) send_item(read_beat(k / 3, k % 3));
    send_item(read_beat(3, 0));
  endtask

  // Size edges: zero rows, wrapping loads, zero distance, saturated sizes.
  task automatic test_size_edges();
    cfg_all(scrg_pkg::SEED_RATIO_RST, scrg_pkg::CROWN_RATIO_RST,
            scrg_pkg::TREE_FLOOR_RST, 0, 0, 5);
    random_frame(2);
    cfg_all(65535, 0, 65535, 1, 4, 4);
    random_frame(0);
    cfg_all(29491, 36045, 512, 0, 3, 3);
    random_frame(0);
    cfg_all(0, 0, 0, 511, 1, 511);
    random_frame(0);
    cfg_all(0, 0, 0, 6, 300, 1);
    random_frame(0);
  endtask

  // Random frames at one sender idle rate.
  task automatic test_random_frames(int pct, int target);
    idle_pct = pct;
    while (items_sent < target) begin
      cfg_all($urandom_range(0, 99) < 10 ? $urandom_range(0, 65535) : $urandom_range(0, 40000),
              $urandom_range(0, 99) < 10 ? $urandom_range(0, 65535) : $urandom_range(0, 50000),
              $urandom_range(0, 99) < 10 ? $urandom_range(0, 65535) : $urandom_range(0, 16'h1000),
              $urandom_range(1, 12), $urandom_range(3, 9), $urandom_range(3, 9));
      random_frame($urandom_range(0, 4) == 0 ? $urandom_range(1, 5) : 0);
    end
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    scrg_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (expected_labels.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %p", $time, out_item);
        fails++;
      end else begin
        want = expected_labels.pop_front();
        if (out_item.out_row !== want.out_row) begin
          $display("%0t: out_row expected %0d got %0d", $time, want.out_row, out_item.out_row);
          fails++;
        end
        if (out_item.out_col !== want.out_col) begin
          $display("%0t: out_col expected %0d got %0d", $time, want.out_col, out_item.out_col);
          fails++;
        end
        if (out_item.crown_label !== want.crown_label) begin
          $display("%0t: crown_label at (%0d,%0d) expected %0d got %0d", $time,
                   want.out_row, want.out_col, want.crown_label, out_item.crown_label);
          fails++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    fails = 0;
    cycles = 0;
    items_sent = 0;
    idle_pct = 21;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int k = 0; k < CELLS; k++) begin
      hgt_mem[k] = '0;
      lbl_mem[k] = '0;
      nxt_mem[k] = '0;
      tested[k] = 1'b0;
      written[k] = 1'b0;
    end
    for (int l = 0; l <= LABEL_TOP; l++) begin
      seed_row[l] = '0;
      seed_col[l] = '0;
      seed_hgt[l] = '0;
    end
    phase = PH_LOADING;
    load_r = 0;
    load_c = 0;
    seed_ratio = scrg_pkg::SEED_RATIO_RST;
    crown_ratio = scrg_pkg::CROWN_RATIO_RST;
    tree_floor = scrg_pkg::TREE_FLOOR_RST;
    max_dist = scrg_pkg::MAX_DIST_RST;
    rows_used = scrg_pkg::ROWS_USED_RST;
    cols_used = scrg_pkg::COLS_USED_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_single_crown();
    test_size_edges();
    test_random_frames(21, items_sent + 80);
    test_random_frames(81, items_sent + 80);
    test_random_frames(0, items_sent + 80);

    settle();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/scrg_pkg.sv
rtl/core/seeded_crown_region_grower.sv
rtl/core/scrg_checker.sv
tb/sv/seeded_crown_region_grower_tb.sv
